[sv/stepper_step_dir_pulse_sequencer_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the step/dir pulse sequencer
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STEPPER_STEP_DIR_PULSE_SEQUENCER_TOP_MACROS_SVH
`define STEPPER_STEP_DIR_PULSE_SEQUENCER_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define STSDP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When the first expression holds, the second must hold in the next cycle.
`define STSDP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[sv/stsdp_pkg.sv]
// ---------------------------------------------------------------------------
// Step/dir pulse sequencer package
// Widths, reset values, codes and the command and status structures that
// join the controller to the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stsdp_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam int KIND_W     = 2;
    localparam int CNT_IN_W   = 16;
    localparam int SPS_W      = 20;
    localparam int PW_W       = 10;
    localparam int SETUP_W    = 10;
    localparam int PERIOD_W   = 20;
    localparam int IDLE_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int DIV_STEPS  = PERIOD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [PERIOD_W-1:0] RATE_DIVIDEND = 20'd1000000;

    localparam logic [PW_W-1:0]     RST_PULSE_WIDTH  = 10'd10;
    localparam logic [SETUP_W-1:0]  RST_EN_SETUP     = 10'd10;
    localparam logic [SETUP_W-1:0]  RST_DIR_SETUP    = 10'd5;
    localparam logic [PERIOD_W-1:0] RST_DEF_PERIOD   = 20'd1000;
    localparam logic [IDLE_W-1:0]   RST_IDLE_TIMEOUT = 24'd3000000;
    localparam logic                RST_DIR_INVERT   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_WIDTH,
        CFG_EN_SETUP,
        CFG_DIR_SETUP,
        CFG_DEF_PERIOD,
        CFG_IDLE_TIMEOUT,
        CFG_DIR_INVERT
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK,
        KIND_MOVE,
        KIND_STOP
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EN_SETUP,
        PH_DIR_SETUP,
        PH_STEP_HIGH,
        PH_STEP_LOW,
        PH_GAP
    } t_phase;

    typedef struct packed {
        logic load;
        logic tick;
        logic stop;
        logic reject;
        logic div_start;
        logic move_load;
        logic advance;
        logic release_chk;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  busy;
        logic  count_nz;
        logic  settled;
        logic  div_done;
    } t_status;

endpackage

`default_nettype wire

[sv/stsdp_in_if.sv]
// ---------------------------------------------------------------------------
// Step/dir pulse sequencer input channel
// Valid/ready channel carrying one tick, move or stop word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stsdp_in_if;
    import stsdp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CNT_IN_W-1:0] step_count;
    logic                direction;
    logic [SPS_W-1:0]    steps_per_second;

    modport source (
        output valid, kind, step_count, direction, steps_per_second,
        input  ready
    );

    modport sink (
        input  valid, kind, step_count, direction, steps_per_second,
        output ready
    );
endinterface

`default_nettype wire

[sv/stsdp_out_if.sv]
// ---------------------------------------------------------------------------
// Step/dir pulse sequencer output channel
// Valid/ready channel carrying the pin levels and flags after each word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stsdp_out_if;
    logic valid;
    logic ready;
    logic step_level;
    logic dir_pin;
    logic enable_pin_n;
    logic busy_res;
    logic command_rejected;

    modport source (
        output valid, step_level, dir_pin, enable_pin_n, busy_res, command_rejected,
        input  ready
    );

    modport sink (
        input  valid, step_level, dir_pin, enable_pin_n, busy_res, command_rejected,
        output ready
    );
endinterface

`default_nettype wire

[sv/stsdp_div.sv]
// ---------------------------------------------------------------------------
// Step rate divider
// Restoring divider that turns a step rate into a period of one-microsecond
// ticks, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stsdp_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [stsdp_pkg::SPS_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic      [stsdp_pkg::PERIOD_W-1:0] o_quotient
);
    import stsdp_pkg::*;

    logic [SPS_W-1:0]     r_div;
    logic [SPS_W-1:0]     r_rem;
    logic [PERIOD_W-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [SPS_W:0]       rem_sh;
    logic [SPS_W:0]       rem_diff;
    logic                 fits;

    always_comb begin
        rem_sh   = {r_rem, r_quo[PERIOD_W-1]};
        rem_diff = rem_sh - {1'b0, r_div};
        fits     = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                r_done <= (r_cnt == DIV_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= RATE_DIVIDEND;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? rem_diff[SPS_W-1:0] : rem_sh[SPS_W-1:0];
            r_quo <= {r_quo[PERIOD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

`default_nettype wire

[sv/stsdp_dp.sv]
// ---------------------------------------------------------------------------
// Step/dir pulse sequencer datapath
// Configuration registers, phase and timer registers, the step rate divider
// and the result register, all driven by commands from the controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_step_dir_pulse_sequencer_top_macros.svh"

module stsdp_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [stsdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [stsdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire stsdp_pkg::t_cmd                  i_cmd,
    output stsdp_pkg::t_status                    o_status,
    input  wire logic [stsdp_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [stsdp_pkg::CNT_IN_W-1:0]   i_step_count,
    input  wire logic                             i_direction,
    input  wire logic [stsdp_pkg::SPS_W-1:0]      i_steps_per_second,
    output logic                                  o_step_level,
    output logic                                  o_dir_pin,
    output logic                                  o_enable_pin_n,
    output logic                                  o_busy_res,
    output logic                                  o_command_rejected
);
    import stsdp_pkg::*;

    logic [PW_W-1:0]     r_pw;
    logic [SETUP_W-1:0]  r_en_setup;
    logic [SETUP_W-1:0]  r_dir_setup;
    logic [PERIOD_W-1:0] r_def_period;
    logic [IDLE_W-1:0]   r_idle_timeout;
    logic                r_dir_invert;

    logic [KIND_W-1:0]   r_kind;
    logic [CNT_IN_W-1:0] r_count;
    logic                r_cmd_dir;
    logic [SPS_W-1:0]    r_sps;

    t_phase                 r_phase,   n_phase;
    logic [PERIOD_W-1:0]    r_timer,   n_timer;
    logic [COUNT_WIDTH-1:0] r_steps,   n_steps;
    logic [PERIOD_W-1:0]    r_period,  n_period;
    logic                   r_dir,     n_dir;
    logic                   r_en_n,    n_en_n;
    logic                   r_moved,   n_moved;
    logic [IDLE_W-1:0]      r_idle,    n_idle;
    logic                   r_pend_dir, n_pend_dir;
    logic                   r_rejected, n_rejected;

    logic r_out_step, r_out_dir, r_out_en_n, r_out_busy, r_out_rej;

    logic [PW_W-1:0]     eff_pw;
    logic [PERIOD_W-1:0] cost;
    logic [PERIOD_W-1:0] gap;
    logic [PERIOD_W-1:0] move_period;
    logic [PERIOD_W-1:0] quotient;
    logic                div_done;
    logic                in_pulse;

    stsdp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (r_sps),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw           <= RST_PULSE_WIDTH;
            r_en_setup     <= RST_EN_SETUP;
            r_dir_setup    <= RST_DIR_SETUP;
            r_def_period   <= RST_DEF_PERIOD;
            r_idle_timeout <= RST_IDLE_TIMEOUT;
            r_dir_invert   <= RST_DIR_INVERT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PULSE_WIDTH:  r_pw           <= i_cfg_data[PW_W-1:0];
                CFG_EN_SETUP:     r_en_setup     <= i_cfg_data[SETUP_W-1:0];
                CFG_DIR_SETUP:    r_dir_setup    <= i_cfg_data[SETUP_W-1:0];
                CFG_DEF_PERIOD:   r_def_period   <= i_cfg_data[PERIOD_W-1:0];
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[IDLE_W-1:0];
                CFG_DIR_INVERT:   r_dir_invert   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_pw = (r_pw == '0) ? PW_W'(1) : r_pw;
        cost   = PERIOD_W'({eff_pw, 1'b0});
        gap    = (r_period > cost) ? (r_period - cost) : '0;

        move_period = (r_sps != '0) ? quotient : r_def_period;
        if (move_period < cost) begin
            move_period = cost;
        end

        n_phase    = r_phase;
        n_timer    = r_timer;
        n_steps    = r_steps;
        n_period   = r_period;
        n_dir      = r_dir;
        n_en_n     = r_en_n;
        n_moved    = r_moved;
        n_idle     = r_idle;
        n_pend_dir = r_pend_dir;
        n_rejected = r_rejected;

        if (i_cmd.load) begin
            n_rejected = 1'b0;
        end
        if (i_cmd.reject) begin
            n_rejected = 1'b1;
        end

        if (i_cmd.tick) begin
            if (r_moved && (r_idle != '1)) begin
                n_idle = r_idle + IDLE_W'(1);
            end
            if ((r_phase != PH_IDLE) && (r_timer != '0)) begin
                n_timer = r_timer - PERIOD_W'(1);
            end
        end

        if (i_cmd.stop) begin
            n_phase = PH_IDLE;
            n_timer = '0;
            n_steps = '0;
            n_en_n  = 1'b1;
            n_moved = 1'b0;
            n_idle  = '0;
        end

        if (i_cmd.move_load) begin
            n_period   = move_period;
            n_steps    = COUNT_WIDTH'(r_count);
            n_pend_dir = r_cmd_dir;
            n_en_n     = 1'b0;
            n_phase    = PH_EN_SETUP;
            n_timer    = PERIOD_W'(r_en_setup);
        end

        if (i_cmd.advance) begin
            unique case (r_phase)
                PH_EN_SETUP: begin
                    n_dir   = r_pend_dir ^ r_dir_invert;
                    n_phase = PH_DIR_SETUP;
                    n_timer = PERIOD_W'(r_dir_setup);
                end
                PH_DIR_SETUP: begin
                    n_phase = PH_STEP_HIGH;
                    n_timer = PERIOD_W'(eff_pw);
                end
                PH_STEP_HIGH: begin
                    n_phase = PH_STEP_LOW;
                    n_timer = PERIOD_W'(eff_pw);
                end
                PH_STEP_LOW: begin
                    if (r_steps != '0) begin
                        n_steps = r_steps - COUNT_WIDTH'(1);
                    end
                    n_moved = 1'b1;
                    n_idle  = '0;
                    n_phase = PH_GAP;
                    n_timer = gap;
                end
                PH_GAP: begin
                    if (r_steps != '0) begin
                        n_phase = PH_STEP_HIGH;
                        n_timer = PERIOD_W'(eff_pw);
                    end else begin
                        n_phase = PH_IDLE;
                        n_timer = '0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            endcase
        end

        if (i_cmd.release_chk && (r_phase == PH_IDLE) && r_moved
                && (r_idle > r_idle_timeout)) begin
            n_en_n  = 1'b1;
            n_moved = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_steps    <= '0;
            r_period   <= '0;
            r_dir      <= 1'b0;
            r_en_n     <= 1'b1;
            r_moved    <= 1'b0;
            r_idle     <= '0;
            r_pend_dir <= 1'b0;
            r_rejected <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_steps    <= n_steps;
            r_period   <= n_period;
            r_dir      <= n_dir;
            r_en_n     <= n_en_n;
            r_moved    <= n_moved;
            r_idle     <= n_idle;
            r_pend_dir <= n_pend_dir;
            r_rejected <= n_rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_count   <= i_step_count;
            r_cmd_dir <= i_direction;
            r_sps     <= i_steps_per_second;
        end
        if (i_cmd.out_load) begin
            r_out_step <= (r_phase == PH_STEP_HIGH);
            r_out_dir  <= r_dir;
            r_out_en_n <= r_en_n;
            r_out_busy <= (r_phase != PH_IDLE);
            r_out_rej  <= r_rejected;
        end
    end

    always_comb begin
        o_status.kind     = t_kind'(r_kind);
        o_status.busy     = (r_phase != PH_IDLE);
        o_status.count_nz = (COUNT_WIDTH'(r_count) != '0);
        o_status.settled  = (r_phase == PH_IDLE) || (r_timer != '0);
        o_status.div_done = div_done;
    end

    assign in_pulse = (r_phase == PH_STEP_HIGH) || (r_phase == PH_STEP_LOW);

    assign o_step_level       = r_out_step;
    assign o_dir_pin          = r_out_dir;
    assign o_enable_pin_n     = r_out_en_n;
    assign o_busy_res         = r_out_busy;
    assign o_command_rejected = r_out_rej;

    `STSDP_ASSERT(a_enabled_while_busy, !o_status.busy || !r_en_n, "driver disabled during a move")
    `STSDP_ASSERT(a_steps_in_pulse, !in_pulse || (r_steps != '0), "pulse with no steps left")
endmodule

`default_nettype wire

[sv/stsdp_ctrl.sv]
// ---------------------------------------------------------------------------
// Step/dir pulse sequencer controller
// Accepts one word at a time, sequences the datapath through the division,
// the phase updates and the loading of the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_step_dir_pulse_sequencer_top_macros.svh"

module stsdp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    input  wire stsdp_pkg::t_status i_status,
    output stsdp_pkg::t_cmd         o_cmd
);
    import stsdp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_SETTLE,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_status.kind)
                    KIND_TICK: begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_SETTLE;
                    end
                    KIND_MOVE: begin
                        if (i_status.busy) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_DONE;
                        end else if (i_status.count_nz) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    KIND_STOP: begin
                        o_cmd.stop = 1'b1;
                        n_state    = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.move_load = 1'b1;
                    n_state         = S_SETTLE;
                end
            end
            S_SETTLE: begin
                if (i_status.settled) begin
                    o_cmd.release_chk = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `STSDP_ASSERT(a_single_command, $onehot0({o_cmd.load, o_cmd.tick, o_cmd.stop, o_cmd.reject, o_cmd.div_start, o_cmd.move_load, o_cmd.advance, o_cmd.release_chk, o_cmd.out_load}), "more than one datapath command")
    `STSDP_ASSERT_NEXT(a_accept_to_exec, i_in_valid && (r_state == S_IDLE), r_state == S_EXEC, "accepted word not dispatched")
    `STSDP_ASSERT(a_div_done_in_div, !i_status.div_done || (r_state == S_DIV), "division finished outside the division state")
endmodule

`default_nettype wire

[sv/stepper_step_dir_pulse_sequencer_top.sv]
// ---------------------------------------------------------------------------
// Step/dir pulse sequencer, top level
// Drives STEP, DIR and active-low EN of a stepper driver from a stream of
// one-microsecond ticks, move commands and stop commands.
//
// The input channel takes one word at a time: a tick, a move (step count,
// direction, steps per second) or a stop. Every word gives exactly one
// result word on the output channel with the pin levels, the busy flag and
// the rejected flag after that word has been applied.
// A tick goes to the settle step, where each phase whose timer has run out
// is advanced; stops, rejected or zero-count moves and unused words go
// straight to the result. A move first runs the restoring divider for the
// period, then loads the sequence and advances any setup phase that is zero.
// The result sits in an output register, so a new word is accepted while
// the previous result waits; if the receiver stalls, the next result is
// held back and the input is not taken until it can be delivered.
// Reset is synchronous and active low: the enable state goes to disabled, the sequence
// is idle and the configuration registers take their default values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepper_step_dir_pulse_sequencer_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [stsdp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [stsdp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    stsdp_in_if.sink                              i_in,
    stsdp_out_if.source                           o_out
);
    import stsdp_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;

    stsdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    stsdp_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_kind             (i_in.kind),
        .i_step_count       (i_in.step_count),
        .i_direction        (i_in.direction),
        .i_steps_per_second (i_in.steps_per_second),
        .o_step_level       (o_out.step_level),
        .o_dir_pin          (o_out.dir_pin),
        .o_enable_pin_n     (o_out.enable_pin_n),
        .o_busy_res         (o_out.busy_res),
        .o_command_rejected (o_out.command_rejected)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
endmodule

`default_nettype wire
